// ===== hw/rtl/gsp_pkg.sv =====
`default_nettype none

package gsp_pkg;

    localparam int SYM_W  = 7;
    localparam int TONE_W = 24;
    localparam int BYTE_W = 8;
    localparam int CS_W   = 9;
    localparam int ACT_W  = 2;
    localparam int IDX_W  = 7;
    localparam int REM_W  = 4;

    localparam logic [ACT_W-1:0] ACT_GPS_BYTE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SYM_TICK  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOAD_SYM  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_LOAD_TONE = 2'd3;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
    localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
    localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

    localparam logic [CS_W-1:0] CS_RESET     = 9'd60;
    localparam logic [CS_W-1:0] CS_HALF_MIN  = 9'd30;
    localparam logic [7:0]      SEC_HALF_MIN = 8'd30;

    // reciprocal of 60 scaled by 2^16, exact for every 9 bit value
    localparam logic [19:0] RECIP_60 = 20'd1093;

    typedef struct packed {
        logic latch;
        logic exec;
        logic parse;
        logic mod_step;
        logic start;
        logic sym_rd;
        logic tone_rd;
        logic tone_ld;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             gga_hit;
        logic             time_match;
        logic             out_busy;
    } status_t;

    function automatic logic [3:0] cycle_minutes(input logic [CS_W-1:0] cs);
        logic [19:0] p;
        p = 20'(cs) * RECIP_60;
        return p[19:16];
    endfunction

    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // two character decimal field, leading blank and sign allowed, modulo 256
    function automatic logic [7:0] two_digit_value(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b);
        logic [7:0] v;
        logic [7:0] da;
        logic [7:0] db;
        da = a - CH_ZERO;
        db = b - CH_ZERO;
        v  = 8'd0;
        if (is_space(a))
        begin
            if (is_digit(b))
            begin
                v = db;
            end
        end
        else if (a == CH_PLUS || a == CH_MINUS)
        begin
            if (is_digit(b))
            begin
                v = db;
            end
            if (a == CH_MINUS)
            begin
                v = 8'd0 - v;
            end
        end
        else if (is_digit(a))
        begin
            if (is_digit(b))
            begin
                v = 8'(da * 8'd10 + db);
            end
            else
            begin
                v = da;
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gsp_ctrl.sv =====
`default_nettype none

module gsp_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire gsp_pkg::status_t status,
    output gsp_pkg::cmd_t         cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_EXEC    = 4'd1;
    localparam logic [3:0] ST_PARSE   = 4'd2;
    localparam logic [3:0] ST_MOD     = 4'd3;
    localparam logic [3:0] ST_MATCH   = 4'd4;
    localparam logic [3:0] ST_SYM_RD  = 4'd5;
    localparam logic [3:0] ST_TONE_RD = 4'd6;
    localparam logic [3:0] ST_TONE_LD = 4'd7;
    localparam logic [3:0] ST_FIN     = 4'd8;

    // four radix-4 steps cover the 8 bit minute value
    localparam logic [1:0] MOD_LAST = 2'd3;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] step_reg;
    logic [1:0] step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                case (status.action)
                    gsp_pkg::ACT_GPS_BYTE: state_next = ST_PARSE;
                    gsp_pkg::ACT_SYM_TICK: state_next = ST_SYM_RD;
                    default:               state_next = ST_FIN;
                endcase
            end
            ST_PARSE:
            begin
                cmd.parse = 1'b1;
                step_next = 2'd0;
                state_next = status.gga_hit ? ST_MOD : ST_FIN;
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                step_next    = step_reg + 2'd1;
                if (step_reg == MOD_LAST)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                if (status.time_match)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SYM_RD;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_SYM_RD:
            begin
                cmd.sym_rd = 1'b1;
                state_next = ST_TONE_RD;
            end
            ST_TONE_RD:
            begin
                cmd.tone_rd = 1'b1;
                state_next  = ST_TONE_LD;
            end
            ST_TONE_LD:
            begin
                cmd.tone_ld = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gsp_datapath.sv =====
`default_nettype none

module gsp_datapath #(
    parameter int MESSAGE_SYMBOLS = 85,
    parameter int TONE_COUNT      = 65,
    parameter int CAPTURE_BYTES   = 15
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [gsp_pkg::CS_W-1:0]      cfg_write_data,
    input  wire logic [gsp_pkg::ACT_W-1:0]     action,
    input  wire logic [gsp_pkg::BYTE_W-1:0]    rx_byte,
    input  wire logic [gsp_pkg::IDX_W-1:0]     table_index,
    input  wire logic [gsp_pkg::TONE_W-1:0]    table_value,
    input  wire gsp_pkg::cmd_t                 cmd,
    output gsp_pkg::status_t                   status,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [gsp_pkg::TONE_W-1:0]         tone_period,
    output logic                               indicator,
    output logic [gsp_pkg::SYM_W-1:0]          symbol_position,
    output logic                               sync_restart,
    output logic                               time_captured
);

    localparam int SAW = (MESSAGE_SYMBOLS > 1) ? $clog2(MESSAGE_SYMBOLS) : 1;
    localparam int TAW = $clog2(TONE_COUNT);
    localparam int CIW = $clog2(CAPTURE_BYTES);
    localparam int CCW = $clog2(CAPTURE_BYTES + 1);

    localparam logic [gsp_pkg::SYM_W-1:0] POS_IDLE = gsp_pkg::SYM_W'(MESSAGE_SYMBOLS);
    localparam logic [gsp_pkg::SYM_W:0]   TONE_LIM = (gsp_pkg::SYM_W + 1)'(TONE_COUNT);
    localparam logic [CCW-1:0]            CAP_LIM  = CCW'(CAPTURE_BYTES);

    // latched input word
    logic [gsp_pkg::ACT_W-1:0]  act_reg;
    logic [gsp_pkg::BYTE_W-1:0] rx_reg;
    logic [gsp_pkg::IDX_W-1:0]  idx_reg;
    logic [gsp_pkg::TONE_W-1:0] val_reg;

    logic [gsp_pkg::CS_W-1:0]   cycle_seconds_reg;

    logic [gsp_pkg::SYM_W-1:0]  symbol_mem [MESSAGE_SYMBOLS];
    logic [gsp_pkg::TONE_W-1:0] tone_mem [TONE_COUNT];

    logic [gsp_pkg::BYTE_W-1:0] cap_buf_reg [CAPTURE_BYTES];
    logic [CCW-1:0]             cap_count_reg;
    logic [CCW-1:0]             cap_count_next;
    logic                       capturing_reg;
    logic                       capturing_next;
    logic                       done_reg;
    logic                       done_next;

    logic [gsp_pkg::SYM_W-1:0]  pos_reg;
    logic [gsp_pkg::TONE_W-1:0] tone_reg;
    logic                       ind_reg;
    logic                       restart_reg;
    logic                       captured_reg;

    logic [7:0]                 min_reg;
    logic [7:0]                 sec_reg;
    logic [gsp_pkg::REM_W-1:0]  rem_reg;

    logic [SAW-1:0]             rd_addr_reg;
    logic [gsp_pkg::SYM_W-1:0]  sym_q_reg;
    logic                       sym_ok_reg;
    logic [gsp_pkg::TONE_W-1:0] tone_q_reg;

    logic                       out_valid_reg;
    logic [gsp_pkg::TONE_W-1:0] out_tone_reg;
    logic                       out_ind_reg;
    logic [gsp_pkg::SYM_W-1:0]  out_pos_reg;
    logic                       out_restart_reg;
    logic                       out_captured_reg;

    logic                       eff_cap;
    logic [CCW-1:0]             eff_cnt;
    logic                       store;
    logic [CCW-1:0]             cnt_inc;
    logic                       gga;
    logic [3:0]                 cm;
    logic                       sym_ok;
    logic                       pos_past_end;

    logic [gsp_pkg::REM_W:0]    r1;
    logic [gsp_pkg::REM_W-1:0]  s1;
    logic [gsp_pkg::REM_W:0]    r2;
    logic [gsp_pkg::REM_W-1:0]  s2;
    logic                       time_match;

    // capture: '$' restarts at slot 0 and is itself stored
    always_comb
    begin
        eff_cap        = capturing_reg || (rx_reg == gsp_pkg::CH_DOLLAR);
        eff_cnt        = (rx_reg == gsp_pkg::CH_DOLLAR) ? '0 : cap_count_reg;
        store          = eff_cap && (eff_cnt < CAP_LIM);
        cnt_inc        = eff_cnt + CCW'(1);
        cap_count_next = eff_cnt;
        capturing_next = eff_cap;
        done_next      = 1'b0;
        if (store)
        begin
            cap_count_next = cnt_inc;
            if (cnt_inc >= CAP_LIM)
            begin
                capturing_next = 1'b0;
                done_next      = 1'b1;
            end
        end
    end

    assign gga = done_reg &&
                 (cap_buf_reg[3] == gsp_pkg::CH_G) &&
                 (cap_buf_reg[4] == gsp_pkg::CH_G) &&
                 (cap_buf_reg[5] == gsp_pkg::CH_A);

    assign cm = gsp_pkg::cycle_minutes(cycle_seconds_reg);

    // minutes mod cycle minutes, two restoring steps per cycle
    always_comb
    begin
        r1 = {rem_reg, min_reg[7]};
        s1 = (r1 >= {1'b0, cm}) ? gsp_pkg::REM_W'(r1 - {1'b0, cm})
                                : gsp_pkg::REM_W'(r1);
        r2 = {s1, min_reg[6]};
        s2 = (r2 >= {1'b0, cm}) ? gsp_pkg::REM_W'(r2 - {1'b0, cm})
                                : gsp_pkg::REM_W'(r2);
    end

    always_comb
    begin
        if (cm == 4'd0)
        begin
            time_match = (cycle_seconds_reg == gsp_pkg::CS_HALF_MIN) &&
                         (sec_reg == 8'd0 || sec_reg == gsp_pkg::SEC_HALF_MIN);
        end
        else
        begin
            time_match = (rem_reg == '0) && (sec_reg == 8'd0);
        end
    end

    assign sym_ok       = {1'b0, sym_q_reg} < TONE_LIM;
    assign pos_past_end = pos_reg >= POS_IDLE;

    assign status.action     = act_reg;
    assign status.gga_hit    = gga;
    assign status.time_match = time_match;
    assign status.out_busy   = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_seconds_reg <= gsp_pkg::CS_RESET;
            cap_count_reg     <= '0;
            capturing_reg     <= 1'b0;
            done_reg          <= 1'b0;
            pos_reg           <= POS_IDLE;
            tone_reg          <= '0;
            ind_reg           <= 1'b0;
            restart_reg       <= 1'b0;
            captured_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                cycle_seconds_reg <= cfg_write_data;
            end
            if (cmd.latch)
            begin
                restart_reg  <= 1'b0;
                captured_reg <= 1'b0;
                done_reg     <= 1'b0;
            end
            if (cmd.exec && act_reg == gsp_pkg::ACT_GPS_BYTE)
            begin
                cap_count_reg <= cap_count_next;
                capturing_reg <= capturing_next;
                done_reg      <= done_next;
            end
            if (cmd.exec && act_reg == gsp_pkg::ACT_SYM_TICK)
            begin
                if (pos_past_end)
                begin
                    ind_reg <= 1'b0;
                end
                else
                begin
                    pos_reg <= pos_reg + gsp_pkg::SYM_W'(1);
                    ind_reg <= ~ind_reg;
                end
            end
            if (cmd.parse)
            begin
                captured_reg <= gga;
            end
            if (cmd.start)
            begin
                pos_reg     <= '0;
                restart_reg <= 1'b1;
            end
            if (cmd.tone_ld)
            begin
                tone_reg <= sym_ok_reg ? tone_q_reg : '0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            act_reg <= action;
            rx_reg  <= rx_byte;
            idx_reg <= table_index;
            val_reg <= table_value;
        end
        if (cmd.exec && act_reg == gsp_pkg::ACT_GPS_BYTE && store)
        begin
            cap_buf_reg[eff_cnt[CIW-1:0]] <= rx_reg;
        end
        if (cmd.exec && act_reg == gsp_pkg::ACT_SYM_TICK)
        begin
            rd_addr_reg <= pos_past_end ? '0 : pos_reg[SAW-1:0];
        end
        if (cmd.parse)
        begin
            min_reg <= gsp_pkg::two_digit_value(cap_buf_reg[9], cap_buf_reg[10]);
            sec_reg <= gsp_pkg::two_digit_value(cap_buf_reg[11], cap_buf_reg[12]);
            rem_reg <= '0;
        end
        if (cmd.mod_step)
        begin
            rem_reg <= s2;
            min_reg <= {min_reg[5:0], 2'b00};
        end
        if (cmd.start)
        begin
            rd_addr_reg <= '0;
        end
        if (cmd.tone_rd)
        begin
            sym_ok_reg <= sym_ok;
        end
        if (cmd.out_load)
        begin
            out_tone_reg     <= tone_reg;
            out_ind_reg      <= ind_reg;
            out_pos_reg      <= pos_reg;
            out_restart_reg  <= restart_reg;
            out_captured_reg <= captured_reg;
        end
    end

    // table storage, registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.exec && act_reg == gsp_pkg::ACT_LOAD_SYM && idx_reg < POS_IDLE)
        begin
            symbol_mem[idx_reg[SAW-1:0]] <= val_reg[gsp_pkg::SYM_W-1:0];
        end
        if (cmd.sym_rd)
        begin
            sym_q_reg <= symbol_mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && act_reg == gsp_pkg::ACT_LOAD_TONE && {1'b0, idx_reg} < TONE_LIM)
        begin
            tone_mem[idx_reg[TAW-1:0]] <= val_reg;
        end
        if (cmd.tone_rd && sym_ok)
        begin
            tone_q_reg <= tone_mem[sym_q_reg[TAW-1:0]];
        end
    end

    assign out_valid       = out_valid_reg;
    assign tone_period     = out_tone_reg;
    assign indicator       = out_ind_reg;
    assign symbol_position = out_pos_reg;
    assign sync_restart    = out_restart_reg;
    assign time_captured   = out_captured_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/gps_synced_symbol_playout.sv =====
// order: exec, then output load once the output is free; a symbol tick adds the
// registered symbol read, tone read and tone load; a gps byte adds a parse, and a
// completed GGA capture adds the 4-step minute modulo unit, a time match and, on a
// start, the tick reads; one word at a time, the next taken after the output load
// reset: period 60 s, player idle at the end position, tone 0, indicator low;
// symbol and tone tables hold no reset value and get no clearing pass
`default_nettype none

module gps_synced_symbol_playout #(
    parameter int MESSAGE_SYMBOLS = 85,
    parameter int TONE_COUNT      = 65,
    parameter int CAPTURE_BYTES   = 15
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write_en,
    input  wire logic [gsp_pkg::CS_W-1:0]   cfg_write_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [gsp_pkg::ACT_W-1:0]  action,
    input  wire logic [gsp_pkg::BYTE_W-1:0] rx_byte,
    input  wire logic [gsp_pkg::IDX_W-1:0]  table_index,
    input  wire logic [gsp_pkg::TONE_W-1:0] table_value,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [gsp_pkg::TONE_W-1:0]      tone_period,
    output logic                            indicator,
    output logic [gsp_pkg::SYM_W-1:0]       symbol_position,
    output logic                            sync_restart,
    output logic                            time_captured
);

    gsp_pkg::cmd_t    cmd;
    gsp_pkg::status_t status;

    gsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    gsp_datapath #(
        .MESSAGE_SYMBOLS (MESSAGE_SYMBOLS),
        .TONE_COUNT      (TONE_COUNT),
        .CAPTURE_BYTES   (CAPTURE_BYTES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .action          (action),
        .rx_byte         (rx_byte),
        .table_index     (table_index),
        .table_value     (table_value),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .tone_period     (tone_period),
        .indicator       (indicator),
        .symbol_position (symbol_position),
        .sync_restart    (sync_restart),
        .time_captured   (time_captured)
    );

endmodule

`default_nettype wire

// ===== dv/gps_synced_symbol_playout_tb.sv =====
`timescale 1ns / 1ps

module gps_synced_symbol_playout_tb;

    import gsp_pkg::*;

    localparam int MSG_SYMS      = 85;
    localparam int TONES         = 65;
    localparam int NMEA_LEN      = 15;
    localparam int SECS_PER_MIN  = 60;
    localparam int HOLD_CYCLES   = 64;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_WORDS  = 2000;

    typedef struct packed {
        logic [TONE_W-1:0] tone;
        logic              ind;
        logic [SYM_W-1:0]  pos;
        logic              restart;
        logic              captured;
    } playout_word_t;

    typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_PERIODIC} ready_mode_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_write_en;
    logic [CS_W-1:0]   cfg_write_data;
    logic              in_valid;
    logic              in_ready;
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] rx_byte;
    logic [IDX_W-1:0]  table_index;
    logic [TONE_W-1:0] table_value;
    logic              out_valid;
    logic              out_ready;
    logic [TONE_W-1:0] tone_period;
    logic              indicator;
    logic [SYM_W-1:0]  symbol_position;
    logic              sync_restart;
    logic              time_captured;

    // own copy of the player state
    logic [SYM_W-1:0]  sym_tbl [MSG_SYMS];
    logic [TONE_W-1:0] tone_tbl [TONES];
    logic [7:0]        nmea_buf [NMEA_LEN];
    int                nmea_cnt;
    bit                nmea_active;
    logic [SYM_W-1:0]  play_pos;
    logic [TONE_W-1:0] tone_now;
    logic              ind_level;
    logic [CS_W-1:0]   period_sec;

    playout_word_t     playout_due [$];
    int                mismatches = 0;
    int                words_sent = 0;
    int                burst_left = 0;
    bit                hold_off_req = 1'b0;

    gps_synced_symbol_playout #(
        .MESSAGE_SYMBOLS (MSG_SYMS),
        .TONE_COUNT      (TONES),
        .CAPTURE_BYTES   (NMEA_LEN)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .rx_byte         (rx_byte),
        .table_index     (table_index),
        .table_value     (table_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .tone_period     (tone_period),
        .indicator       (indicator),
        .symbol_position (symbol_position),
        .sync_restart    (sync_restart),
        .time_captured   (time_captured)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // atoi over two characters, kept modulo 256
    function automatic logic [7:0] field_value(input logic [7:0] c0, input logic [7:0] c1);
        logic [7:0] ch [2];
        int         k;
        int         acc;
        bit         minus;
        ch[0] = c0;
        ch[1] = c1;
        k     = 0;
        acc   = 0;
        minus = 1'b0;
        if (c0 == CH_SPACE || (c0 >= CH_TAB && c0 <= CH_CR))
            k = 1;
        if (k < 2 && (ch[k] == CH_PLUS || ch[k] == CH_MINUS))
        begin
            minus = (ch[k] == CH_MINUS);
            k++;
        end
        while (k < 2 && ch[k] >= CH_ZERO && ch[k] <= CH_NINE)
        begin
            acc = acc * 10 + int'(ch[k] - CH_ZERO);
            k++;
        end
        if (minus)
            acc = -acc;
        return acc[7:0];
    endfunction

    function automatic bit start_due(input logic [7:0] mins, input logic [7:0] secs);
        int cm;
        cm = int'(period_sec) / SECS_PER_MIN;
        if (cm == 0)
            return period_sec == CS_HALF_MIN && (secs == 8'd0 || secs == SEC_HALF_MIN);
        return (int'(mins) % cm) == 0 && secs == 8'd0;
    endfunction

    function automatic logic [TONE_W-1:0] tone_at(input int pos);
        logic [SYM_W-1:0] s;
        if (pos >= MSG_SYMS)
            return '0;
        s = sym_tbl[pos];
        if (s >= TONES)
            return '0;
        return tone_tbl[s];
    endfunction

    function automatic playout_word_t playout_advance(input logic [ACT_W-1:0] act,
                                                      input logic [7:0] rx,
                                                      input logic [IDX_W-1:0] idx,
                                                      input logic [TONE_W-1:0] val);
        playout_word_t r;
        logic [7:0]    mins;
        logic [7:0]    secs;
        r.restart  = 1'b0;
        r.captured = 1'b0;
        case (act)
            ACT_GPS_BYTE:
            begin
                if (rx == CH_DOLLAR)
                begin
                    nmea_cnt    = 0;
                    nmea_active = 1'b1;
                end
                if (nmea_active && nmea_cnt < NMEA_LEN)
                begin
                    nmea_buf[nmea_cnt] = rx;
                    nmea_cnt++;
                    if (nmea_cnt >= NMEA_LEN)
                    begin
                        nmea_active = 1'b0;
                        if (nmea_buf[3] == CH_G && nmea_buf[4] == CH_G && nmea_buf[5] == CH_A)
                        begin
                            mins       = field_value(nmea_buf[9], nmea_buf[10]);
                            secs       = field_value(nmea_buf[11], nmea_buf[12]);
                            r.captured = 1'b1;
                            if (start_due(mins, secs))
                            begin
                                play_pos  = '0;
                                tone_now  = tone_at(0);
                                r.restart = 1'b1;
                            end
                        end
                    end
                end
            end
            ACT_SYM_TICK:
            begin
                if (play_pos >= MSG_SYMS)
                begin
                    tone_now  = tone_at(0);
                    ind_level = 1'b0;
                end
                else
                begin
                    tone_now  = tone_at(play_pos);
                    play_pos  = play_pos + 1'b1;
                    ind_level = ~ind_level;
                end
            end
            ACT_LOAD_SYM:
            begin
                if (idx < MSG_SYMS)
                    sym_tbl[idx] = val[SYM_W-1:0];
            end
            default:
            begin
                if (idx < TONES)
                    tone_tbl[idx] = val;
            end
        endcase
        r.tone = tone_now;
        r.ind  = ind_level;
        r.pos  = play_pos;
        return r;
    endfunction

    function automatic logic [7:0] other_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_DOLLAR);
        return b;
    endfunction

    function automatic logic [7:0] odd_time_char();
        case ($urandom_range(0, 7))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_CR;
            3: return "\n";
            4: return CH_PLUS;
            5: return CH_MINUS;
            6: return "Z";
            default: return other_byte();
        endcase
    endfunction

    // low bits mostly a real tone index, now and then past the end of the tone table
    function automatic logic [TONE_W-1:0] symbol_value();
        logic [TONE_W-1:0] v;
        v = TONE_W'($urandom_range(0, 24'hFFFFFF));
        v[SYM_W-1:0] = ($urandom_range(0, 7) == 0) ? SYM_W'($urandom_range(TONES, 127))
                                                   : SYM_W'($urandom_range(0, TONES - 1));
        return v;
    endfunction

    task automatic send_word(input logic [ACT_W-1:0] act, input logic [7:0] rx,
                             input logic [IDX_W-1:0] idx, input logic [TONE_W-1:0] val);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 20);
        end
        in_valid    <= 1'b1;
        action      <= act;
        rx_byte     <= rx;
        table_index <= idx;
        table_value <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        playout_due.push_back(playout_advance(act, rx, idx, val));
        burst_left--;
        words_sent++;
    endtask

    task automatic send_gps(input logic [7:0] b);
        send_word(ACT_GPS_BYTE, b, IDX_W'($urandom_range(0, 127)),
                  TONE_W'($urandom_range(0, 24'hFFFFFF)));
    endtask

    task automatic send_tick();
        send_word(ACT_SYM_TICK, 8'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 127)),
                  TONE_W'($urandom_range(0, 24'hFFFFFF)));
    endtask

    task automatic send_random_load();
        logic [IDX_W-1:0] idx;
        if ($urandom_range(0, 1))
        begin
            idx = ($urandom_range(0, 7) == 0) ? IDX_W'($urandom_range(MSG_SYMS, 127))
                                              : IDX_W'($urandom_range(0, MSG_SYMS - 1));
            send_word(ACT_LOAD_SYM, 8'($urandom_range(0, 255)), idx, symbol_value());
        end
        else
        begin
            idx = ($urandom_range(0, 7) == 0) ? IDX_W'($urandom_range(TONES, 127))
                                              : IDX_W'($urandom_range(0, TONES - 1));
            send_word(ACT_LOAD_TONE, 8'($urandom_range(0, 255)), idx,
                      TONE_W'($urandom_range(0, 24'hFFFFFF)));
        end
    endtask

    // $xxGGA,hhmmss.s cut to the captured length; minutes and seconds as given
    task automatic send_time_sentence(input bit gga, input logic [7:0] m0, input logic [7:0] m1,
                                      input logic [7:0] s0, input logic [7:0] s1);
        logic [7:0] s [NMEA_LEN];
        s[0] = CH_DOLLAR;
        s[1] = CH_G;
        s[2] = "P";
        s[3] = CH_G;
        s[4] = CH_G;
        s[5] = CH_A;
        if (!gga)
        begin
            case ($urandom_range(0, 3))
                0: {s[3], s[4], s[5]} = "RMC";
                1: {s[3], s[4], s[5]} = "GSA";
                2: {s[3], s[4], s[5]} = "GGB";
                default:
                begin
                    s[3] = other_byte();
                    s[4] = other_byte();
                    s[5] = other_byte();
                    if (s[3] == CH_G && s[4] == CH_G && s[5] == CH_A)
                        s[5] = "B";
                end
            endcase
        end
        s[6]  = ",";
        s[7]  = CH_ZERO + 8'($urandom_range(0, 2));
        s[8]  = CH_ZERO + 8'($urandom_range(0, 9));
        s[9]  = m0;
        s[10] = m1;
        s[11] = s0;
        s[12] = s1;
        s[13] = ".";
        s[14] = CH_ZERO + 8'($urandom_range(0, 9));
        foreach (s[i])
            send_gps(s[i]);
    endtask

    task automatic send_random_sentence(input bit gga);
        int         cm;
        int         mm;
        int         ss;
        logic [7:0] t [4];
        cm = int'(period_sec) / SECS_PER_MIN;
        if (cm > 0 && $urandom_range(0, 1))
            mm = cm * $urandom_range(0, 59 / cm);
        else
            mm = $urandom_range(0, 59);
        case ($urandom_range(0, 3))
            0, 1: ss = 0;
            2: ss = 30;
            default: ss = $urandom_range(0, 59);
        endcase
        t[0] = CH_ZERO + 8'(mm / 10);
        t[1] = CH_ZERO + 8'(mm % 10);
        t[2] = CH_ZERO + 8'(ss / 10);
        t[3] = CH_ZERO + 8'(ss % 10);
        // blanks, signs and junk in the time digits
        foreach (t[i])
        begin
            if ($urandom_range(0, 5) == 0)
                t[i] = odd_time_char();
        end
        send_time_sentence(gga, t[0], t[1], t[2], t[3]);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (playout_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_cycle_seconds(input logic [CS_W-1:0] secs);
        wait_results_drained();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= secs;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        period_sec = secs;
    endtask

    // every entry gets written before anything can read the tables
    task automatic test_table_load();
        for (int i = 0; i < MSG_SYMS; i++)
            send_word(ACT_LOAD_SYM, 8'($urandom_range(0, 255)), IDX_W'(i), symbol_value());
        for (int i = 0; i < TONES; i++)
            send_word(ACT_LOAD_TONE, 8'($urandom_range(0, 255)), IDX_W'(i),
                      TONE_W'($urandom_range(0, 24'hFFFFFF)));
    endtask

    task automatic test_directed_cases();
        send_word(ACT_LOAD_TONE, 8'h00, 7'd0, 24'hFFFFFF);
        send_word(ACT_LOAD_TONE, 8'hFF, 7'd64, 24'h000000);
        send_word(ACT_LOAD_TONE, 8'h00, 7'd65, 24'hABCDEF);
        send_word(ACT_LOAD_TONE, 8'h00, 7'd127, 24'h123456);
        // symbol value bits above the low seven are dropped
        send_word(ACT_LOAD_SYM, 8'h00, 7'd0, 24'hFFFF80);
        send_word(ACT_LOAD_SYM, 8'h00, 7'd1, 24'd64);
        send_word(ACT_LOAD_SYM, 8'h00, 7'd84, 24'd127);
        send_word(ACT_LOAD_SYM, 8'h00, 7'd85, 24'd3);
        send_word(ACT_LOAD_SYM, 8'h00, 7'd127, 24'd5);
        // idle ticks replay symbol 0 with the indicator low
        send_tick();
        send_tick();
        send_time_sentence(1'b1, CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO);
        send_tick();
        send_tick();
    endtask

    task automatic test_input_backpressure();
        hold_off_req = 1'b1;
        burst_left   = 60;
        repeat (40) send_tick();
        wait_results_drained();
    endtask

    task automatic run_random_mix(input int count);
        int stop_at;
        int pick;
        int n;
        stop_at = words_sent + count;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                send_random_sentence(1'b1);
            else if (pick < 38)
                send_random_sentence(1'b0);
            else if (pick < 45)
            begin
                // sentence cut short by a fresh '$'
                n = $urandom_range(1, NMEA_LEN - 1);
                send_gps(CH_DOLLAR);
                repeat (n - 1) send_gps(other_byte());
                send_random_sentence(1'b1);
            end
            else if (pick < 75)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 100) : $urandom_range(1, 30);
                repeat (n) send_tick();
            end
            else if (pick < 88)
                send_random_load();
            else
                repeat ($urandom_range(1, 6)) send_gps(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_period_settings();
        logic [CS_W-1:0] periods [9];
        periods = '{9'd60, 9'd15, 9'd30, 9'd45, 9'd90, 9'd120, 9'd180, 9'd240, 9'd300};
        foreach (periods[i])
        begin
            set_cycle_seconds(periods[i]);
            run_random_mix(RANDOM_WORDS / 9);
        end
    endtask

    // receiver stall pattern, plus one long hold-off on request
    initial
    begin
        ready_mode_t mode;
        int          mode_left;
        mode      = RDY_ALWAYS;
        mode_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = ready_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    RDY_ALWAYS:   out_ready <= 1'b1;
                    RDY_HALF:     out_ready <= 1'($urandom_range(0, 1));
                    RDY_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
                    default:      out_ready <= mode_left[2];
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        playout_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (playout_due.size() == 0)
            begin
                $error("unexpected word: tone_period %06h symbol_position %0d",
                       tone_period, symbol_position);
                mismatches++;
            end
            else
            begin
                want = playout_due.pop_front();
                if (tone_period !== want.tone)
                begin
                    $error("tone_period: expected %06h, got %06h", want.tone, tone_period);
                    mismatches++;
                end
                if (indicator !== want.ind)
                begin
                    $error("indicator: expected %0b, got %0b", want.ind, indicator);
                    mismatches++;
                end
                if (symbol_position !== want.pos)
                begin
                    $error("symbol_position: expected %0d, got %0d", want.pos, symbol_position);
                    mismatches++;
                end
                if (sync_restart !== want.restart)
                begin
                    $error("sync_restart: expected %0b, got %0b", want.restart, sync_restart);
                    mismatches++;
                end
                if (time_captured !== want.captured)
                begin
                    $error("time_captured: expected %0b, got %0b", want.captured, time_captured);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("gps_synced_symbol_playout verification failed");
        $finish;
    end

    initial
    begin
        nmea_cnt    = 0;
        nmea_active = 1'b0;
        play_pos    = SYM_W'(MSG_SYMS);
        tone_now    = '0;
        ind_level   = 1'b0;
        period_sec  = CS_RESET;

        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        action         <= ACT_GPS_BYTE;
        rx_byte        <= '0;
        table_index    <= '0;
        table_value    <= '0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= CS_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_load();
        test_directed_cases();
        test_input_backpressure();
        test_period_settings();
        wait_results_drained();

        if (mismatches == 0)
            $display("gps_synced_symbol_playout verification clean");
        else
            $display("gps_synced_symbol_playout verification failed");
        $finish;
    end

endmodule

// ===== gps_synced_symbol_playout.f =====
hw/rtl/gsp_pkg.sv
hw/rtl/gsp_ctrl.sv
hw/rtl/gsp_datapath.sv
hw/rtl/gps_synced_symbol_playout.sv
dv/gps_synced_symbol_playout_tb.sv
